[hdl/jsu_pkg.sv]
// Shared constants and types for the Jacobi five-point stencil block.
// No dependencies; imported by the top level.
package jsu_pkg;

   localparam int MAX_COLS_DEFAULT   = 1024;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam int ROW_WIDTH_BITS = 11;
   localparam int ROW_COUNT_BITS = 16;
   localparam int PADDR_BITS     = 3;
   localparam int PDATA_BITS     = 32;
   localparam int MIN_DIM        = 3;

   localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 11'd1024;
   localparam logic [ROW_COUNT_BITS-1:0] ROW_COUNT_RESET = 16'd1024;

   typedef enum logic {
      CSR_ROW_WIDTH = 1'b0,
      CSR_ROW_COUNT = 1'b1
   } csr_index_type;

endpackage

[hdl/jsu_ram.sv]
// Generic simple dual-port RAM: one write port, two registered read ports.
// Read-before-write on a shared address. No dependencies.
module jsu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_en,
   input  logic [$clog2(DEPTH)-1:0] read_addr_a,
   input  logic [$clog2(DEPTH)-1:0] read_addr_b,
   output logic [WIDTH-1:0]         read_data_a,
   output logic [WIDTH-1:0]         read_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (read_en) begin
         rd_a_ff <= mem_ff[read_addr_a];
         rd_b_ff <= mem_ff[read_addr_b];
      end
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   assign read_data_a = rd_a_ff;
   assign read_data_b = rd_b_ff;

endmodule

[hdl/jacobi_stencil_update.sv]
// Jacobi five-point stencil, one sweep over a raster-ordered grid stream.
// Depends on jsu_pkg and two jsu_ram row banks.
//
// Usage:
//  req_ channel carries one grid cell per request, raster order, row by row.
//  rsp_ channel returns the updated value of an interior cell together with
//  its row and column; rsp_last flags the final interior cell of the grid.
//  Border cells return nothing.
//  APB registers: row_width at 0x0, row_count at 0x4; out-of-range values are
//  clamped when used. A write restarts the grid at row 0, column 0.
// Timing:
//  One request per cycle sustained while the output does not stall. A result
//  passes through the registered row-bank reads in the read stage, then through
//  the adder into the output register.
//  The row banks give one write and two reads per cycle, which sets the rate.
// Reset: synchronous; clears the position counters and pipeline valids and
//  loads both registers with 1024. Row banks are not cleared; an entry is
//  always written before its value is used.
// Stall: a stalled result holds in the output register while one more request
//  is taken into the read stage; req_stall rises once both hold a result.
module jacobi_stencil_update
   import jsu_pkg::*;
#(
   parameter int MAX_COLS   = MAX_COLS_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [VALUE_BITS-1:0]         req_cell_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [VALUE_BITS-1:0]         rsp_new_value,
   output logic [ROW_COUNT_BITS-1:0]     rsp_out_row,
   output logic [$clog2(MAX_COLS)-1:0]   rsp_out_col,
   output logic                          rsp_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [PADDR_BITS-1:0]         paddr,
   input  logic [PDATA_BITS-1:0]         pwdata,
   output logic [PDATA_BITS-1:0]         prdata,
   output logic                          pready
);

   localparam int COL_BITS = $clog2(MAX_COLS);
   localparam int WB       = COL_BITS + 1;
   localparam int RB       = ROW_COUNT_BITS + 1;

   // registers
   logic [ROW_WIDTH_BITS-1:0] row_width_ff;
   logic [ROW_COUNT_BITS-1:0] row_count_ff;
   csr_index_type             csr_idx;
   logic                      cfg_we;

   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[2]);
   assign cfg_we  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         row_count_ff <= ROW_COUNT_RESET;
      end else if (cfg_we) begin
         unique case (csr_idx)
            CSR_ROW_WIDTH: row_width_ff <= pwdata[ROW_WIDTH_BITS-1:0];
            CSR_ROW_COUNT: row_count_ff <= pwdata[ROW_COUNT_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_ROW_WIDTH: prdata = PDATA_BITS'(row_width_ff);
         CSR_ROW_COUNT: prdata = PDATA_BITS'(row_count_ff);
      endcase
   end

   // clamped grid size
   logic [WB-1:0]             w_eff;
   logic [ROW_COUNT_BITS-1:0] h_eff;

   always_comb begin
      priority if (int'(row_width_ff) < MIN_DIM) begin
         w_eff = WB'(MIN_DIM);
      end else if (int'(row_width_ff) > MAX_COLS) begin
         w_eff = WB'(MAX_COLS);
      end else begin
         w_eff = WB'(row_width_ff);
      end
      if (int'(row_count_ff) < MIN_DIM) begin
         h_eff = ROW_COUNT_BITS'(MIN_DIM);
      end else begin
         h_eff = row_count_ff;
      end
   end

   // handshake
   logic s1_valid_ff, s1_has_ff, out_valid_ff;
   logic out_free, s1_adv, s1_free, accept;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && (!s1_has_ff || out_free);
   assign s1_free   = !s1_valid_ff || s1_adv;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   // position counters
   logic [COL_BITS-1:0]       col_ff, col_in;
   logic [ROW_COUNT_BITS-1:0] row_ff, row_in;
   logic                      bank_ff, bank_in;
   logic [WB-1:0]             col_p1_w, col_p2_w;
   logic [RB-1:0]             row_p1_w;
   logic                      col_end, row_end, has_result, is_last;

   assign col_p1_w   = {1'b0, col_ff} + WB'(1);
   assign col_p2_w   = {1'b0, col_ff} + WB'(2);
   assign row_p1_w   = {1'b0, row_ff} + RB'(1);
   assign col_end    = col_p1_w >= w_eff;
   assign row_end    = row_p1_w >= {1'b0, h_eff};
   assign has_result = (row_ff >= ROW_COUNT_BITS'(2)) && (col_ff != '0) && !col_end;
   assign is_last    = (row_p1_w == {1'b0, h_eff}) && (col_p2_w == w_eff);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      bank_in = bank_ff;
      if (cfg_we) begin
         col_in  = '0;
         row_in  = '0;
         bank_in = 1'b0;
      end else if (accept) begin
         if (col_end) begin
            col_in = '0;
            if (row_end) begin
               row_in  = '0;
               bank_in = 1'b0;
            end else begin
               row_in  = row_p1_w[ROW_COUNT_BITS-1:0];
               bank_in = !bank_ff;
            end
         end else begin
            col_in = col_p1_w[COL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         bank_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         bank_ff <= bank_in;
      end
   end

   // row banks: older bank written and read at col, newer read at col-1 and col+1
   logic [COL_BITS-1:0]   col_m1, col_p1;
   logic [VALUE_BITS-1:0] b0_a, b0_b, b1_a, b1_b;

   assign col_m1 = (col_ff == '0) ? '0 : col_ff - COL_BITS'(1);
   assign col_p1 = (col_ff == COL_BITS'(MAX_COLS - 1)) ? col_ff : col_ff + COL_BITS'(1);

   jsu_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_COLS)) u_bank0 (
      .clock       (clock),
      .write_en    (accept && !bank_ff),
      .write_addr  (col_ff),
      .write_data  (req_cell_value),
      .read_en     (accept),
      .read_addr_a (bank_ff ? col_m1 : col_ff),
      .read_addr_b (col_p1),
      .read_data_a (b0_a),
      .read_data_b (b0_b)
   );

   jsu_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_COLS)) u_bank1 (
      .clock       (clock),
      .write_en    (accept && bank_ff),
      .write_addr  (col_ff),
      .write_data  (req_cell_value),
      .read_en     (accept),
      .read_addr_a (bank_ff ? col_ff : col_m1),
      .read_addr_b (col_p1),
      .read_data_a (b1_a),
      .read_data_b (b1_b)
   );

   // read stage
   logic                      s1_last_ff, s1_bank_ff;
   logic [VALUE_BITS-1:0]     s1_value_ff;
   logic [ROW_COUNT_BITS-1:0] s1_row_ff;
   logic [COL_BITS-1:0]       s1_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_has_ff   <= has_result;
         s1_last_ff  <= is_last;
         s1_bank_ff  <= bank_ff;
         s1_value_ff <= req_cell_value;
         s1_row_ff   <= row_ff - ROW_COUNT_BITS'(1);
         s1_col_ff   <= col_ff;
      end
   end

   logic [VALUE_BITS-1:0] up, left, right;
   logic [VALUE_BITS+1:0] sum;

   assign up    = s1_bank_ff ? b1_a : b0_a;
   assign left  = s1_bank_ff ? b0_a : b1_a;
   assign right = s1_bank_ff ? b0_b : b1_b;
   assign sum   = {2'b00, up} + {2'b00, left} + {2'b00, right} + {2'b00, s1_value_ff};

   // output register
   logic [VALUE_BITS-1:0]     out_value_ff;
   logic [ROW_COUNT_BITS-1:0] out_row_ff;
   logic [COL_BITS-1:0]       out_col_ff;
   logic                      out_last_ff;
   logic                      out_load;

   assign out_load = s1_adv && s1_has_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= out_load;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_value_ff <= sum[VALUE_BITS+1:2];
         out_row_ff   <= s1_row_ff;
         out_col_ff   <= s1_col_ff;
         out_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_new_value = out_value_ff;
   assign rsp_out_row   = out_row_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_last      = out_last_ff;

`ifndef SYNTH
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      cfg_we |=> (col_ff == '0 && row_ff == '0 && !bank_ff))
      else $error("grid position not cleared by register write");

   a_border_col: assert property (@(posedge clock) disable iff (reset)
      (accept && col_ff == '0) |=> !s1_has_ff)
      else $error("left border cell marked as producing a result");

   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_row != '0 && rsp_out_col != '0))
      else $error("result on a border cell");
`endif

endmodule

[tb/tb_jacobi_stencil_update.sv]
// Self-checking testbench for jacobi_stencil_update: streams raster-ordered grids,
// predicts each interior update in a scoreboard class and checks every response.
// Depends on jsu_pkg and the jacobi_stencil_update RTL.
`timescale 1ns / 1ps

module tb_jacobi_stencil_update;
   import jsu_pkg::*;

   localparam int COLS         = MAX_COLS_DEFAULT;
   localparam int VBITS        = VALUE_BITS_DEFAULT;
   localparam int COL_BITS     = $clog2(COLS);
   localparam int SUM_BITS     = VBITS + 2;
   localparam int HOLD_CYCLES  = 100;
   localparam int WIDE_COLS    = 300;
   localparam int RANDOM_CELLS = 876;

   typedef struct packed {
      logic [VBITS-1:0]          new_value;
      logic [ROW_COUNT_BITS-1:0] row;
      logic [COL_BITS-1:0]       col;
      logic                      last;
   } cell_update_type;

   class stencil_scoreboard_type;
      logic [VBITS-1:0]          row_bank [2][COLS];
      bit                        bank_sel = 1'b0;
      int unsigned               row_pos = 0;
      int unsigned               col_pos = 0;
      logic [ROW_WIDTH_BITS-1:0] width_reg = ROW_WIDTH_RESET;
      logic [ROW_COUNT_BITS-1:0] count_reg = ROW_COUNT_RESET;
      cell_update_type           pending_updates [$];
      int                        errors = 0;

      function int unsigned cols_in_use();
         if (width_reg < MIN_DIM) return MIN_DIM;
         if (width_reg > COLS) return COLS;
         return width_reg;
      endfunction

      function int unsigned rows_in_use();
         if (count_reg < MIN_DIM) return MIN_DIM;
         return count_reg;
      endfunction

      // any register write restarts the grid; row banks keep their contents
      function void write_register(csr_index_type idx, logic [PDATA_BITS-1:0] data);
         if (idx == CSR_ROW_WIDTH) begin
            width_reg = data[ROW_WIDTH_BITS-1:0];
         end else begin
            count_reg = data[ROW_COUNT_BITS-1:0];
         end
         row_pos  = 0;
         col_pos  = 0;
         bank_sel = 1'b0;
      endfunction

      function void note_cell(logic [VBITS-1:0] v);
         int unsigned      w, h, r, c;
         logic [SUM_BITS-1:0] total;
         cell_update_type  u;
         w = cols_in_use();
         h = rows_in_use();
         r = row_pos;
         c = col_pos;
         if (r >= h) r = h - 1;
         if (c >= w) c = w - 1;
         if (r >= 2 && c >= 1 && c + 1 < w) begin
            total = SUM_BITS'(row_bank[bank_sel][c]) + SUM_BITS'(v)
                  + SUM_BITS'(row_bank[!bank_sel][c-1]) + SUM_BITS'(row_bank[!bank_sel][c+1]);
            u.new_value = total[SUM_BITS-1:2];
            u.row       = ROW_COUNT_BITS'(r - 1);
            u.col       = COL_BITS'(c);
            u.last      = (r + 1 == h) && (c + 2 == w);
            pending_updates.push_back(u);
         end
         row_bank[bank_sel][c] = v;
         if (c + 1 >= w) begin
            col_pos  = 0;
            bank_sel = !bank_sel;
            if (r + 1 >= h) begin
               row_pos  = 0;
               bank_sel = 1'b0;
            end else begin
               row_pos = r + 1;
            end
         end else begin
            col_pos = c + 1;
            row_pos = r;
         end
      endfunction

      function void check_result(cell_update_type got);
         cell_update_type want;
         if (pending_updates.size() == 0) begin
            $error("unexpected update at row %0d col %0d", got.row, got.col);
            errors++;
            return;
         end
         want = pending_updates.pop_front();
         if (got.new_value !== want.new_value) begin
            $error("new_value: expected %h, got %h", want.new_value, got.new_value);
            errors++;
         end
         if (got.row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, got.row);
            errors++;
         end
         if (got.col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, got.col);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [VBITS-1:0]          req_cell_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [VBITS-1:0]          rsp_new_value;
   logic [ROW_COUNT_BITS-1:0] rsp_out_row;
   logic [COL_BITS-1:0]       rsp_out_col;
   logic                      rsp_last;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [PADDR_BITS-1:0]     paddr;
   logic [PDATA_BITS-1:0]     pwdata;
   logic [PDATA_BITS-1:0]     prdata;
   logic                      pready;

   stencil_scoreboard_type sb;
   bit                sender_steady;
   bit                receiver_steady;
   bit                hold_receiver;
   logic [VBITS-1:0]  probe_grid [9] = '{32'h0, 32'h1, 32'h0, 32'h2, 32'h3,
                                         32'hFFFF_FFFF, 32'h8000_0000, 32'h3, 32'hFFFF_FFFC};

   jacobi_stencil_update uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_new_value  (rsp_new_value),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_last       (rsp_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [VBITS-1:0] pick_cell();
      unique case ($urandom_range(0, 7))
         0: return '1;
         1: return '0;
         2: return VBITS'($urandom_range(0, 3));
         3: return '1 - VBITS'($urandom_range(0, 3));
         default: return VBITS'($urandom);
      endcase
   endfunction

   // entered and left at a falling edge
   task automatic send_cell(input logic [VBITS-1:0] v);
      int gap;
      gap = sender_steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cell_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_cell(v);
      @(negedge clock);
   endtask

   task automatic send_cells(input int count);
      repeat (count) send_cell(pick_cell());
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [PDATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.write_register(idx, data);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // border cells give no update, so allow the pipeline to empty as well
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending_updates.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      int stall_len;
      cell_update_type got;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_receiver) begin
            hold_receiver = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall_len = receiver_steady ? 0 : idle_gap();
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         if (rsp_valid) begin
            got.new_value = rsp_new_value;
            got.row       = rsp_out_row;
            got.col       = rsp_out_col;
            got.last      = rsp_last;
            sb.check_result(got);
         end
         @(negedge clock);
      end
   end

   initial begin
      #8000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int w, h, ew, eh, grids, partial, cells, phase, random_cells;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cell_value  = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      hold_receiver   = 1'b0;
      sb = new;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // clamped 3x3 grid at full scale, then a second grid straight after the wrap
      csr_write(CSR_ROW_WIDTH, 0);
      csr_write(CSR_ROW_COUNT, 2);
      repeat (9) send_cell('1);
      foreach (probe_grid[i]) send_cell(probe_grid[i]);
      wait_drained();
      csr_write(CSR_ROW_WIDTH, 3);
      csr_write(CSR_ROW_COUNT, 16'hFFFF);
      send_cells(9);
      wait_drained();
      csr_write(CSR_ROW_WIDTH, 11'h7FF);
      csr_write(CSR_ROW_COUNT, 0);
      send_cells(3);
      wait_drained();

      // wide grid, with one mid-grid pause until all updates are back
      csr_write(CSR_ROW_WIDTH, WIDE_COLS);
      csr_write(CSR_ROW_COUNT, 3);
      for (int i = 0; i < 3 * WIDE_COLS; i++) begin
         if (i == 750) wait_drained();
         send_cell(pick_cell());
      end
      wait_drained();

      // receiver holds off while requests keep coming, so the block back-pressures
      csr_write(CSR_ROW_COUNT, 12);
      csr_write(CSR_ROW_WIDTH, 12);
      sender_steady = 1'b1;
      hold_receiver = 1'b1;
      send_cells(144);
      sender_steady = 1'b0;
      wait_drained();

      phase = 0;
      random_cells = 0;
      while (random_cells < RANDOM_CELLS) begin
         unique case ($urandom_range(0, 19))
            0: w = $urandom_range(0, 2);
            1: w = $urandom_range(40, 120);
            default: w = $urandom_range(3, 20);
         endcase
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
         if (w > 20) h = $urandom_range(3, 4);
         if ($urandom_range(0, 1)) begin
            csr_write(CSR_ROW_WIDTH, w);
            csr_write(CSR_ROW_COUNT, h);
         end else begin
            csr_write(CSR_ROW_COUNT, h);
            csr_write(CSR_ROW_WIDTH, w);
         end
         ew = sb.cols_in_use();
         eh = sb.rows_in_use();
         grids = (w > 20) ? 1 : $urandom_range(1, 3);
         partial = ($urandom_range(0, 2) == 0) ? $urandom_range(1, ew * eh - 1) : 0;
         cells = grids * ew * eh + partial;
         if (cells > RANDOM_CELLS - random_cells) cells = RANDOM_CELLS - random_cells;
         sender_steady   = (phase % 5 == 3);
         receiver_steady = (phase % 5 == 3) || (phase % 7 == 2);
         send_cells(cells);
         random_cells += cells;
         sender_steady   = 1'b0;
         receiver_steady = 1'b0;
         wait_drained();
         phase++;
      end

      wait_drained();
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[files.f]
hdl/jsu_pkg.sv
hdl/jsu_ram.sv
hdl/jacobi_stencil_update.sv
tb/tb_jacobi_stencil_update.sv
